// File: sv/rgbkf_pkg.sv
// Shared types and constants for the RGB 3x3 kernel filter.
// No dependencies; the other files that use it refer to this package by scoped names.
`default_nettype none
package rgbkf_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int CFG_W             = 11;
    localparam int COORD_W           = 10;
    localparam int PIX_W             = 24;
    localparam int NTAPS             = 9;

    // register indexes of the write port
    localparam logic REG_KERNEL_MODE = 1'b0;
    localparam logic REG_IMAGE_SIZE  = 1'b1;

    localparam logic [2:0]  KERNEL_MODE_RESET = 3'd0;
    localparam logic [10:0] IMAGE_SIZE_RESET  = 11'd1024;

    localparam logic [2:0] MODE_BOX       = 3'd0;
    localparam logic [2:0] MODE_TRIM      = 3'd1;
    localparam logic [2:0] MODE_SHARP     = 3'd2;
    localparam logic [2:0] MODE_ROW_BLUR  = 3'd3;
    localparam logic [2:0] MODE_ROW_SHARP = 3'd4;

    // reciprocals for truncating division of small sums, scaled by 2^DIV_SHIFT
    localparam int          DIV_SHIFT = 16;
    localparam logic [13:0] RECIP9    = 14'd7282;
    localparam logic [13:0] RECIP7    = 14'd9363;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last;
    } result_t;

    // what travels beside the kernel pipeline
    typedef struct packed {
        logic             iv;
        logic             bv;
        logic [9:0]       irow;
        logic [9:0]       icol;
        logic [9:0]       brow;
        logic [9:0]       bcol;
        logic [PIX_W-1:0] bpix;
    } tag_t;

endpackage
`default_nettype wire

// File: sv/rgbkf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rgbkf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: sv/rgbkf_cell.sv
// One window cell: holds a pixel and hands it to its neighbor on each shift.
// Depends on rgbkf_pkg.
`default_nettype none
module rgbkf_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         shift,
    input  wire logic [rgbkf_pkg::PIX_W-1:0]  d,
    output logic      [rgbkf_pkg::PIX_W-1:0]  q
);

    logic [rgbkf_pkg::PIX_W-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// File: sv/rgbkf_kernel.sv
// Three-stage 3x3 kernel datapath: intensity min/max, channel sums, divide and clamp.
// Depends on rgbkf_pkg.
`default_nettype none
module rgbkf_kernel (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      en,
    input  wire logic [2:0]                                mode,
    input  wire logic                                      in_valid,
    input  wire rgbkf_pkg::tag_t                           in_tag,
    input  wire logic [rgbkf_pkg::NTAPS-1:0][rgbkf_pkg::PIX_W-1:0] in_pix,
    output logic                                           out_valid,
    output rgbkf_pkg::tag_t                                out_tag,
    output logic      [rgbkf_pkg::PIX_W-1:0]               out_pix
);

    logic                                                   k1_valid_reg;
    rgbkf_pkg::tag_t                                        k1_tag_reg;
    logic [rgbkf_pkg::NTAPS-1:0][rgbkf_pkg::PIX_W-1:0]      k1_pix_reg;

    logic                                                   k2_valid_reg;
    rgbkf_pkg::tag_t                                        k2_tag_reg;
    logic [rgbkf_pkg::NTAPS-1:0][rgbkf_pkg::PIX_W-1:0]      k2_pix_reg;
    logic [3:0]                                             k2_lo_reg;
    logic [3:0]                                             k2_hi_reg;
    logic [3:0]                                             k2_lo_next;
    logic [3:0]                                             k2_hi_next;

    logic                                                   k3_valid_reg;
    rgbkf_pkg::tag_t                                        k3_tag_reg;
    logic [2:0][12:0]                                       k3_s_reg;
    logic [2:0][12:0]                                       k3_s_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_valid_reg <= 1'b0;
            k2_valid_reg <= 1'b0;
            k3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k1_valid_reg <= in_valid;
            k2_valid_reg <= k1_valid_reg;
            k3_valid_reg <= k2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_tag_reg <= in_tag;
            k1_pix_reg <= in_pix;
            k2_tag_reg <= k1_tag_reg;
            k2_pix_reg <= k1_pix_reg;
            k2_lo_reg  <= k2_lo_next;
            k2_hi_reg  <= k2_hi_next;
            k3_tag_reg <= k2_tag_reg;
            k3_s_reg   <= k3_s_next;
        end
    end

    // min keeps the later pixel on ties, max the earlier
    always_comb
    begin
        logic [9:0] t;
        logic [9:0] lo_val;
        logic [9:0] hi_val;
        lo_val     = {2'b0, k1_pix_reg[0][23:16]} + {2'b0, k1_pix_reg[0][15:8]}
                   + {2'b0, k1_pix_reg[0][7:0]};
        hi_val     = lo_val;
        k2_lo_next = 4'd0;
        k2_hi_next = 4'd0;
        for (int i = 1; i < rgbkf_pkg::NTAPS; i++)
        begin
            t = {2'b0, k1_pix_reg[i][23:16]} + {2'b0, k1_pix_reg[i][15:8]}
              + {2'b0, k1_pix_reg[i][7:0]};
            if (t <= lo_val)
            begin
                lo_val     = t;
                k2_lo_next = 4'(i);
            end
            if (t > hi_val)
            begin
                hi_val     = t;
                k2_hi_next = 4'(i);
            end
        end
    end

    always_comb
    begin
        logic [12:0] v [rgbkf_pkg::NTAPS];
        logic [12:0] sum;
        logic [12:0] drop;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = '0;
            for (int i = 0; i < rgbkf_pkg::NTAPS; i++)
            begin
                v[i] = {5'b0, k2_pix_reg[i][8*ch +: 8]};
                sum  = sum + v[i];
            end
            drop = v[k2_lo_reg] + v[k2_hi_reg];
            case (mode)
                rgbkf_pkg::MODE_BOX:       k3_s_next[ch] = sum;
                rgbkf_pkg::MODE_TRIM:      k3_s_next[ch] = sum - drop;
                rgbkf_pkg::MODE_SHARP:     k3_s_next[ch] = (v[4] << 3) + (v[4] << 1) - sum;
                rgbkf_pkg::MODE_ROW_BLUR:  k3_s_next[ch] = v[3] + (v[4] << 1) + v[5];
                rgbkf_pkg::MODE_ROW_SHARP: k3_s_next[ch] = (v[4] << 1) + v[4] - v[3] - v[5];
                default:                   k3_s_next[ch] = v[4];
            endcase
        end
    end

    always_comb
    begin
        logic [25:0] prod;
        logic [12:0] q;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod = '0;
            case (mode)
                rgbkf_pkg::MODE_BOX:
                begin
                    prod = k3_s_reg[ch][11:0] * rgbkf_pkg::RECIP9;
                    q    = {3'b0, prod[rgbkf_pkg::DIV_SHIFT +: 10]};
                end
                rgbkf_pkg::MODE_TRIM:
                begin
                    prod = k3_s_reg[ch][11:0] * rgbkf_pkg::RECIP7;
                    q    = {3'b0, prod[rgbkf_pkg::DIV_SHIFT +: 10]};
                end
                rgbkf_pkg::MODE_ROW_BLUR: q = {2'b0, k3_s_reg[ch][12:2]};
                default:                  q = k3_s_reg[ch];
            endcase
            if (q[12])
            begin
                out_pix[8*ch +: 8] = 8'd0;
            end
            else if (q[11:8] != 4'd0)
            begin
                out_pix[8*ch +: 8] = 8'd255;
            end
            else
            begin
                out_pix[8*ch +: 8] = q[7:0];
            end
        end
    end

    assign out_valid = k3_valid_reg;
    assign out_tag   = k3_tag_reg;

endmodule
`default_nettype wire

// File: sv/rgb_3x3_kernel_filter_top.sv
// Top level of the RGB 3x3 kernel filter: counters, line stores, window cells,
// result pairing and output register. Depends on rgbkf_pkg, rgbkf_ram, rgbkf_cell, rgbkf_kernel.
//
// Usage:
//   pixel/pixel_valid/pixel_ready carries one RGB pixel per word in raster order
//   over a square image of image_size pixels a side. result/result_valid/result_ready
//   returns finished pixels tagged with row and column. Border pixels pass through;
//   interior pixel (r-1,c-1) is produced when pixel (r,c) arrives, ahead of any
//   border result of that same pixel; last marks the final result of each pixel.
//   Throughput: one pixel per clock while each pixel gives at most one result and
//   result_ready stays high; pixels that give two results (last column, last row)
//   hold the input while both leave by the single output port. After its pixel is
//   accepted a result goes through the input register with the line-store RAM read
//   beside it, three kernel stages, the pairing register and the output register.
//   Reset clears counters, window and registers (kernel_mode 0, image_size 1024);
//   line stores are not cleared and their data is only used once written by the image.
//   When result_ready is low the pipeline advances until the pairing register is full;
//   then it holds and pixel_ready drops. Write the registers only while idle.
`default_nettype none
module rgb_3x3_kernel_filter_top #(
    parameter int MAX_WIDTH = rgbkf_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pixel_valid,
    output logic                             pixel_ready,
    input  wire rgbkf_pkg::pixel_t           pixel,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output rgbkf_pkg::result_t               result,
    input  wire logic                        write_en,
    input  wire logic                        write_index,
    input  wire logic [rgbkf_pkg::CFG_W-1:0] write_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int NW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (NW + 1 > 12) ? NW + 1 : 12;
    localparam int PW   = rgbkf_pkg::PIX_W;

    logic [2:0]                  kernel_mode_reg;
    logic [rgbkf_pkg::CFG_W-1:0] image_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg <= rgbkf_pkg::KERNEL_MODE_RESET;
            image_size_reg  <= rgbkf_pkg::IMAGE_SIZE_RESET;
        end
        else if (write_en)
        begin
            case (write_index)
                rgbkf_pkg::REG_KERNEL_MODE: kernel_mode_reg <= write_data[2:0];
                rgbkf_pkg::REG_IMAGE_SIZE:  image_size_reg  <= write_data;
                default:                    ;
            endcase
        end
    end

    // advance enable for the whole pipeline
    logic adv;
    logic accept;

    // ---------------- position counters ----------------
    logic [CW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CMPW-1:0] n_a, size_a, row_a, col_a, r_tmp, r_cur, c_cur, cn, rn;
    logic            interior, border;

    always_comb
    begin
        size_a = CMPW'(image_size_reg);
        if (size_a < CMPW'(3))
        begin
            n_a = CMPW'(3);
        end
        else if (size_a > CMPW'(MAX_WIDTH))
        begin
            n_a = CMPW'(MAX_WIDTH);
        end
        else
        begin
            n_a = size_a;
        end
        row_a = CMPW'(row_reg);
        col_a = CMPW'(col_reg);
        // size may shrink between frames: wrap before use
        if (col_a >= n_a)
        begin
            c_cur = '0;
            r_tmp = row_a + CMPW'(1);
        end
        else
        begin
            c_cur = col_a;
            r_tmp = row_a;
        end
        r_cur    = (r_tmp >= n_a) ? '0 : r_tmp;
        interior = (r_cur >= CMPW'(2)) && (c_cur >= CMPW'(2));
        border   = (r_cur == '0) || (r_cur == n_a - CMPW'(1))
                || (c_cur == '0) || (c_cur == n_a - CMPW'(1));
        cn = c_cur + CMPW'(1);
        rn = r_cur + CMPW'(1);
        if (cn >= n_a)
        begin
            col_next = '0;
            row_next = (rn >= n_a) ? '0 : CW'(rn);
        end
        else
        begin
            col_next = CW'(cn);
            row_next = CW'(r_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------- stage 1: line-store read ----------------
    logic            s1_valid_reg;
    logic [PW-1:0]   s1_pix_reg;
    logic [CW-1:0]   s1_col_reg;
    rgbkf_pkg::tag_t s1_tag_reg;
    rgbkf_pkg::tag_t s1_tag_next;
    logic [CMPW-1:0] ri, ci;

    always_comb
    begin
        ri              = r_cur - CMPW'(1);
        ci              = c_cur - CMPW'(1);
        s1_tag_next.iv   = interior;
        s1_tag_next.bv   = border;
        s1_tag_next.irow = ri[9:0];
        s1_tag_next.icol = ci[9:0];
        s1_tag_next.brow = r_cur[9:0];
        s1_tag_next.bcol = c_cur[9:0];
        s1_tag_next.bpix = pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg <= pixel;
            s1_col_reg <= c_cur[CW-1:0];
            s1_tag_reg <= s1_tag_next;
        end
    end

    logic [PW-1:0] top_pix, mid_pix;
    logic          s1_move;

    assign s1_move = adv && s1_valid_reg;

    rgbkf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (mid_pix),
        .re    (adv),
        .raddr (c_cur[CW-1:0]),
        .rdata (top_pix)
    );

    rgbkf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (adv),
        .raddr (c_cur[CW-1:0]),
        .rdata (mid_pix)
    );

    // ---------------- window: three rows of two cells ----------------
    logic [PW-1:0] w0, w1, w2, w3, w4, w5;

    rgbkf_cell u_cell0 (.clk(clk), .rst_n(rst_n), .shift(s1_move), .d(w1),         .q(w0));
    rgbkf_cell u_cell1 (.clk(clk), .rst_n(rst_n), .shift(s1_move), .d(top_pix),    .q(w1));
    rgbkf_cell u_cell2 (.clk(clk), .rst_n(rst_n), .shift(s1_move), .d(w3),         .q(w2));
    rgbkf_cell u_cell3 (.clk(clk), .rst_n(rst_n), .shift(s1_move), .d(mid_pix),    .q(w3));
    rgbkf_cell u_cell4 (.clk(clk), .rst_n(rst_n), .shift(s1_move), .d(w5),         .q(w4));
    rgbkf_cell u_cell5 (.clk(clk), .rst_n(rst_n), .shift(s1_move), .d(s1_pix_reg), .q(w5));

    logic [rgbkf_pkg::NTAPS-1:0][PW-1:0] taps;

    always_comb
    begin
        taps[0] = w0;
        taps[1] = w1;
        taps[2] = top_pix;
        taps[3] = w2;
        taps[4] = w3;
        taps[5] = mid_pix;
        taps[6] = w4;
        taps[7] = w5;
        taps[8] = s1_pix_reg;
    end

    logic            k_valid;
    rgbkf_pkg::tag_t k_tag;
    logic [PW-1:0]   k_pix;

    rgbkf_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .mode      (kernel_mode_reg),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .in_pix    (taps),
        .out_valid (k_valid),
        .out_tag   (k_tag),
        .out_pix   (k_pix)
    );

    // ---------------- pairing register and output register ----------------
    logic               p_iv_reg, p_iv_next;
    logic               p_bv_reg, p_bv_next;
    rgbkf_pkg::tag_t    p_tag_reg;
    logic [PW-1:0]      p_ipix_reg;
    logic               res_valid_reg, res_valid_next;
    rgbkf_pkg::result_t res_reg, res_next;
    logic               out_free;

    always_comb
    begin
        out_free       = !res_valid_reg || result_ready;
        p_iv_next      = p_iv_reg;
        p_bv_next      = p_bv_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (out_free)
        begin
            res_valid_next = p_iv_reg || p_bv_reg;
            if (p_iv_reg)
            begin
                res_next.out_row   = p_tag_reg.irow;
                res_next.out_col   = p_tag_reg.icol;
                res_next.out_red   = p_ipix_reg[23:16];
                res_next.out_green = p_ipix_reg[15:8];
                res_next.out_blue  = p_ipix_reg[7:0];
                res_next.last      = !p_bv_reg;
                p_iv_next          = 1'b0;
            end
            else
            begin
                res_next.out_row   = p_tag_reg.brow;
                res_next.out_col   = p_tag_reg.bcol;
                res_next.out_red   = p_tag_reg.bpix[23:16];
                res_next.out_green = p_tag_reg.bpix[15:8];
                res_next.out_blue  = p_tag_reg.bpix[7:0];
                res_next.last      = 1'b1;
                p_bv_next          = 1'b0;
            end
        end
        adv = !p_iv_next && !p_bv_next;
        if (adv && k_valid)
        begin
            p_iv_next = k_tag.iv;
            p_bv_next = k_tag.bv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_iv_reg      <= 1'b0;
            p_bv_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            p_iv_reg      <= p_iv_next;
            p_bv_reg      <= p_bv_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (adv && k_valid)
        begin
            p_tag_reg  <= k_tag;
            p_ipix_reg <= k_pix;
        end
    end

    assign accept       = pixel_valid && adv;
    assign pixel_ready  = adv;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire
